/* rtl/pdll_pkg.sv */
// ----------------------------------------------------------------------------
// pdll_pkg
// Shared types and constants for the pooled doubly linked list: beat
// structs, operation and status codes, and the store interface structs.
// ----------------------------------------------------------------------------
package pdll_pkg;

    // pool geometry and storage width
    localparam int POOL_SLOTS  = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int SLOT_W      = $clog2(POOL_SLOTS);

    // fixed field widths of the beats
    localparam int FIELD_W    = 32;
    localparam int SLOT_IDX_W = 5;

    typedef logic [SLOT_W-1:0]             slot_t;
    typedef logic signed [VALUE_WIDTH-1:0] value_t;

    // request kinds
    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_WALK   = 2'd3
    } kind_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    // input beat
    typedef struct packed {
        kind_t                     kind;
        logic signed [FIELD_W-1:0] key;
        logic signed [FIELD_W-1:0] new_value;
    } in_beat_t;

    // result beat
    typedef struct packed {
        status_t                   status;
        logic signed [FIELD_W-1:0] item_value;
        logic [SLOT_IDX_W-1:0]     slot_index;
        logic [SLOT_IDX_W-1:0]     entry_count;
        logic                      last;
    } out_beat_t;

    // store access from the sequencer
    typedef struct packed {
        slot_t  rd_addr;
        logic   val_we;
        slot_t  val_addr;
        value_t val_data;
        logic   nxt_we;
        slot_t  nxt_addr;
        slot_t  nxt_data;
        logic   prv_we;
        slot_t  prv_addr;
        slot_t  prv_data;
    } mem_req_t;

    // registered read data of the store
    typedef struct packed {
        value_t val;
        slot_t  nxt;
        slot_t  prv;
    } mem_rd_t;

endpackage

/* rtl/pooled_doubly_linked_list.sv */
// ----------------------------------------------------------------------------
// pooled_doubly_linked_list
// Doubly linked list of signed values in a fixed slot pool, with append,
// insert after key, delete key and walk requests, each answered by status
// beats.
//
//   channel  dir  ports                        beat
//   s_       in   s_valid s_ready s_data       one request (in_beat_t)
//   m_       out  m_valid m_ready m_data       one result  (out_beat_t)
//
// One request at a time; s_ready is high only while the sequencer idles.
// Key search does a registered store read and a compare per node visited;
// the free-slot scan after append/insert looks at up to 31 slots. Walk reads
// each node and emits it as one beat. aresetn resets state, head, tail, free,
// count, pool-full, the slot-used bits and m_valid; the memories keep data.
// A stalled m_ready holds the sequencer in its emit step once the output
// register is full; a request's final beat parks there and s_ready returns.
// ----------------------------------------------------------------------------
module pooled_doubly_linked_list (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pdll_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pdll_pkg::out_beat_t m_data
);
    import pdll_pkg::*;

    logic      res_valid;
    logic      res_ready;
    out_beat_t res_beat;
    mem_req_t  mem_req;
    mem_rd_t   mem_rd;

    logic      m_valid_reg, m_valid_next;
    out_beat_t m_data_reg, m_data_next;

    pdll_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req_beat  (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_beat  (res_beat),
        .mem_req   (mem_req),
        .mem_rd    (mem_rd)
    );

    pdll_store u_store (
        .aclk    (aclk),
        .mem_req (mem_req),
        .mem_rd  (mem_rd)
    );

    // output register
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            m_data_next  = res_beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* rtl/pdll_store.sv */
// ----------------------------------------------------------------------------
// pdll_store
// Node storage: value, next link and previous link memories, each with
// one write port and a registered read at a shared address.
// ----------------------------------------------------------------------------
module pdll_store (
    input  logic               aclk,
    input  pdll_pkg::mem_req_t mem_req,
    output pdll_pkg::mem_rd_t  mem_rd
);
    import pdll_pkg::*;

    value_t val_mem [POOL_SLOTS];
    slot_t  nxt_mem [POOL_SLOTS];
    slot_t  prv_mem [POOL_SLOTS];

    // writes
    always_ff @(posedge aclk) begin
        if (mem_req.val_we) begin
            val_mem[mem_req.val_addr] <= mem_req.val_data;
        end
        if (mem_req.nxt_we) begin
            nxt_mem[mem_req.nxt_addr] <= mem_req.nxt_data;
        end
        if (mem_req.prv_we) begin
            prv_mem[mem_req.prv_addr] <= mem_req.prv_data;
        end
    end

    // registered read, one node per cycle
    always_ff @(posedge aclk) begin
        mem_rd.val <= val_mem[mem_req.rd_addr];
        mem_rd.nxt <= nxt_mem[mem_req.rd_addr];
        mem_rd.prv <= prv_mem[mem_req.rd_addr];
    end

endmodule

/* rtl/pdll_ctrl.sv */
// ----------------------------------------------------------------------------
// pdll_ctrl
// Sequencer for the list: key search over the links, node linking and
// unlinking, circular free-slot scan and the walk, one request at a time.
// ----------------------------------------------------------------------------
module pdll_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                req_valid,
    output logic                req_ready,
    input  pdll_pkg::in_beat_t  req_beat,
    output logic                res_valid,
    input  logic                res_ready,
    output pdll_pkg::out_beat_t res_beat,
    output pdll_pkg::mem_req_t  mem_req,
    input  pdll_pkg::mem_rd_t   mem_rd
);
    import pdll_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_FIND_RD  = 12'b0000_0000_0010,
        S_FIND_CHK = 12'b0000_0000_0100,
        S_APP_A    = 12'b0000_0000_1000,
        S_APP_B    = 12'b0000_0001_0000,
        S_INS_A    = 12'b0000_0010_0000,
        S_INS_B    = 12'b0000_0100_0000,
        S_DEL      = 12'b0000_1000_0000,
        S_SCAN     = 12'b0001_0000_0000,
        S_WALK_RD  = 12'b0010_0000_0000,
        S_WALK_GET = 12'b0100_0000_0000,
        S_EMIT     = 12'b1000_0000_0000
    } state_t;

    localparam slot_t LAST_SLOT  = SLOT_W'(POOL_SLOTS - 1);
    localparam slot_t SCAN_LIMIT = SLOT_W'(POOL_SLOTS - 2);
    localparam slot_t SLOT_NULL  = '0;
    localparam slot_t SLOT_ONE   = SLOT_W'(1);

    // control state
    state_t                  state_reg, state_next;
    slot_t                   head_reg, head_next;
    slot_t                   tail_reg, tail_next;
    slot_t                   free_reg, free_next;
    logic                    full_reg, full_next;
    slot_t                   count_reg, count_next;
    logic [POOL_SLOTS-1:0]   used_reg, used_next;

    // working registers
    kind_t   op_reg, op_next;
    value_t  key_reg, key_next;
    value_t  nv_reg, nv_next;
    slot_t   cur_reg, cur_next;
    slot_t   cnt_reg, cnt_next;
    slot_t   tgt_reg, tgt_next;
    slot_t   p_reg, p_next;
    slot_t   q_reg, q_next;
    slot_t   nxt_reg, nxt_next;
    status_t res_status_reg, res_status_next;
    value_t  res_value_reg, res_value_next;
    slot_t   res_slot_reg, res_slot_next;
    logic    res_last_reg, res_last_next;

    // shared unit: key compare and circular slot step
    logic  key_hit;
    slot_t cand;

    assign key_hit = (mem_rd.val == key_reg);
    assign cand    = (cur_reg == LAST_SLOT) ? SLOT_ONE : cur_reg + SLOT_ONE;

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_EMIT);

    // result beat
    always_comb begin
        res_beat.status      = res_status_reg;
        res_beat.item_value  = FIELD_W'(res_value_reg);
        res_beat.slot_index  = SLOT_IDX_W'(res_slot_reg);
        res_beat.entry_count = SLOT_IDX_W'(count_reg);
        res_beat.last        = res_last_reg;
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        free_next       = free_reg;
        full_next       = full_reg;
        count_next      = count_reg;
        used_next       = used_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        nv_next         = nv_reg;
        cur_next        = cur_reg;
        cnt_next        = cnt_reg;
        tgt_next        = tgt_reg;
        p_next          = p_reg;
        q_next          = q_reg;
        nxt_next        = nxt_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_slot_next   = res_slot_reg;
        res_last_next   = res_last_reg;

        mem_req          = '0;
        mem_req.rd_addr  = cur_reg;

        unique case (state_reg)
            S_IDLE: begin
                res_status_next = ST_OK;
                res_value_next  = '0;
                res_slot_next   = SLOT_NULL;
                res_last_next   = 1'b1;
                cur_next        = head_reg;
                cnt_next        = SLOT_NULL;
                if (req_valid) begin
                    op_next  = req_beat.kind;
                    key_next = value_t'(req_beat.key);
                    nv_next  = value_t'(req_beat.new_value);
                    unique case (req_beat.kind)
                        KIND_APPEND: begin
                            if (full_reg) begin
                                res_status_next = ST_FULL;
                                state_next      = S_EMIT;
                            end else begin
                                state_next = S_APP_A;
                            end
                        end
                        KIND_INSERT: begin
                            if (full_reg) begin
                                res_status_next = ST_FULL;
                                state_next      = S_EMIT;
                            end else if (head_reg == SLOT_NULL) begin
                                res_status_next = ST_NOTFOUND;
                                state_next      = S_EMIT;
                            end else begin
                                state_next = S_FIND_RD;
                            end
                        end
                        KIND_DELETE: begin
                            if (head_reg == SLOT_NULL) begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_EMIT;
                            end else begin
                                state_next = S_FIND_RD;
                            end
                        end
                        KIND_WALK: begin
                            if (head_reg == SLOT_NULL) begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_EMIT;
                            end else begin
                                state_next = S_WALK_RD;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end

            // read the node under test
            S_FIND_RD: begin
                state_next = S_FIND_CHK;
            end

            // compare its value with the key, else follow the next link or report not found at the end
            S_FIND_CHK: begin
                if (key_hit) begin
                    tgt_next = cur_reg;
                    p_next   = mem_rd.prv;
                    q_next   = mem_rd.nxt;
                    if (op_reg == KIND_DELETE) begin
                        state_next = S_DEL;
                    end else if (cur_reg == tail_reg) begin
                        state_next = S_APP_A;
                    end else begin
                        state_next = S_INS_A;
                    end
                end else if (mem_rd.nxt == SLOT_NULL || cnt_reg == LAST_SLOT) begin
                    res_status_next = ST_NOTFOUND;
                    state_next      = S_EMIT;
                end else begin
                    cur_next   = mem_rd.nxt;
                    cnt_next   = cnt_reg + SLOT_ONE;
                    state_next = S_FIND_RD;
                end
            end

            // append: value, back link, old tail forward link
            S_APP_A: begin
                mem_req.val_we   = 1'b1;
                mem_req.val_addr = free_reg;
                mem_req.val_data = nv_reg;
                mem_req.prv_we   = 1'b1;
                mem_req.prv_addr = free_reg;
                mem_req.prv_data = (head_reg == SLOT_NULL) ? SLOT_NULL : tail_reg;
                if (head_reg != SLOT_NULL) begin
                    mem_req.nxt_we   = 1'b1;
                    mem_req.nxt_addr = tail_reg;
                    mem_req.nxt_data = free_reg;
                end
                state_next = S_APP_B;
            end

            // append: terminate new node, move tail
            S_APP_B: begin
                mem_req.nxt_we   = 1'b1;
                mem_req.nxt_addr = free_reg;
                mem_req.nxt_data = SLOT_NULL;
                used_next[free_reg] = 1'b1;
                if (head_reg == SLOT_NULL) begin
                    head_next = free_reg;
                end
                tail_next     = free_reg;
                count_next    = count_reg + SLOT_ONE;
                res_slot_next = free_reg;
                cur_next      = free_reg;
                cnt_next      = SLOT_NULL;
                state_next    = S_SCAN;
            end

            // insert: fill the new node between target and its successor
            S_INS_A: begin
                mem_req.val_we   = 1'b1;
                mem_req.val_addr = free_reg;
                mem_req.val_data = nv_reg;
                mem_req.prv_we   = 1'b1;
                mem_req.prv_addr = free_reg;
                mem_req.prv_data = tgt_reg;
                mem_req.nxt_we   = 1'b1;
                mem_req.nxt_addr = free_reg;
                mem_req.nxt_data = q_reg;
                state_next       = S_INS_B;
            end

            // insert: relink neighbours to the new node
            S_INS_B: begin
                mem_req.prv_we   = 1'b1;
                mem_req.prv_addr = q_reg;
                mem_req.prv_data = free_reg;
                mem_req.nxt_we   = 1'b1;
                mem_req.nxt_addr = tgt_reg;
                mem_req.nxt_data = free_reg;
                used_next[free_reg] = 1'b1;
                count_next    = count_reg + SLOT_ONE;
                res_slot_next = free_reg;
                cur_next      = free_reg;
                cnt_next      = SLOT_NULL;
                state_next    = S_SCAN;
            end

            // delete: unlink the node and release its slot
            S_DEL: begin
                if (p_reg == SLOT_NULL) begin
                    head_next = q_reg;
                end else begin
                    mem_req.nxt_we   = 1'b1;
                    mem_req.nxt_addr = p_reg;
                    mem_req.nxt_data = q_reg;
                end
                if (q_reg == SLOT_NULL) begin
                    tail_next = p_reg;
                end else begin
                    mem_req.prv_we   = 1'b1;
                    mem_req.prv_addr = q_reg;
                    mem_req.prv_data = p_reg;
                end
                used_next[tgt_reg] = 1'b0;
                count_next         = count_reg - SLOT_ONE;
                if (full_reg) begin
                    full_next = 1'b0;
                    free_next = tgt_reg;
                end
                res_slot_next = tgt_reg;
                state_next    = S_EMIT;
            end

            // circular free-slot scan, one slot per cycle
            S_SCAN: begin
                cur_next = cand;
                cnt_next = cnt_reg + SLOT_ONE;
                if (!used_reg[cand]) begin
                    free_next  = cand;
                    state_next = S_EMIT;
                end else if (cnt_reg == SCAN_LIMIT) begin
                    full_next  = 1'b1;
                    state_next = S_EMIT;
                end
            end

            // walk: read the current node
            S_WALK_RD: begin
                state_next = S_WALK_GET;
            end

            // walk: capture value and link for the beat
            S_WALK_GET: begin
                res_status_next = ST_OK;
                res_value_next  = mem_rd.val;
                res_slot_next   = cur_reg;
                res_last_next   = (mem_rd.nxt == SLOT_NULL) || (cnt_reg == SCAN_LIMIT);
                nxt_next        = mem_rd.nxt;
                state_next      = S_EMIT;
            end

            // hand the beat over, then finish or continue the walk
            S_EMIT: begin
                if (res_ready) begin
                    if (res_last_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        cur_next   = nxt_reg;
                        cnt_next   = cnt_reg + SLOT_ONE;
                        state_next = S_WALK_RD;
                    end
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= SLOT_NULL;
            tail_reg  <= SLOT_NULL;
            free_reg  <= SLOT_ONE;
            full_reg  <= 1'b0;
            count_reg <= SLOT_NULL;
            used_reg  <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            free_reg  <= free_next;
            full_reg  <= full_next;
            count_reg <= count_next;
            used_reg  <= used_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        nv_reg         <= nv_next;
        cur_reg        <= cur_next;
        cnt_reg        <= cnt_next;
        tgt_reg        <= tgt_next;
        p_reg          <= p_next;
        q_reg          <= q_next;
        nxt_reg        <= nxt_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_slot_reg   <= res_slot_next;
        res_last_reg   <= res_last_next;
    end

endmodule
